/* hdl/hdt_pkg.sv */
// Shared types and constants for the data channel hop tracker.
`timescale 1ns / 1ps
`default_nettype none
package hdt_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned IVL_BITS      = 22;
  localparam int unsigned GUARD_BITS    = 16;
  localparam int unsigned US_PER_UNIT   = 1250;
  localparam int unsigned NUM_DATA_CH   = 37;

  localparam logic [GUARD_BITS-1:0] HOP_GUARD_RST  = 16'd7000;
  localparam logic [GUARD_BITS-1:0] SKIP_GUARD_RST = 16'd4000;
  localparam logic [IVL_BITS-1:0]   INTERVAL_MAX   = {IVL_BITS{1'b1}};
  localparam logic [36:0]           FULL_MAP       = {37{1'b1}};

  // tracking modes
  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_WAIT_FIRST = 2'd1;
  localparam logic [1:0] MODE_TIMED_HOP  = 2'd2;
  localparam logic [1:0] MODE_WAIT_HOP   = 2'd3;

  // configuration register indexes
  localparam logic CFG_HOP_GUARD  = 1'b0;
  localparam logic CFG_SKIP_GUARD = 1'b1;

  typedef struct packed {
    logic        crc_ok;
    logic        link_request;
    logic [4:0]  hop_increment;
    logic [11:0] conn_interval;
    logic [36:0] channel_map;
    logic [31:0] link_access_addr;
    logic [23:0] link_crc_init;
    logic [31:0] now_us;
  } hdt_in_t;

  typedef struct packed {
    logic [5:0]  channel;
    logic        retune;
    logic        load_link;
    logic [31:0] access_addr_out;
    logic [23:0] crc_init_out;
    logic        hop_refused;
    logic [1:0]  track_state;
  } hdt_out_t;

endpackage
`default_nettype wire

/* hdl/hdt_core.sv */
// Tracker state registers and the single-step next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none
module hdt_core #(
  parameter int unsigned TimeBits = hdt_pkg::TIME_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                step_i,
  input  wire hdt_pkg::hdt_in_t                    item_i,
  input  wire logic [hdt_pkg::GUARD_BITS-1:0]      hop_guard_i,
  input  wire logic [hdt_pkg::GUARD_BITS-1:0]      skip_guard_i,
  output hdt_pkg::hdt_out_t                        res_o
);

  localparam int unsigned IvlW = hdt_pkg::IVL_BITS;

  function automatic logic [5:0] next_ch(input logic [5:0] ch, input logic [4:0] hop);
    logic [6:0] sum;
    sum = {1'b0, ch} + {2'b00, hop};
    if (sum >= 7'(hdt_pkg::NUM_DATA_CH)) begin
      sum = sum - 7'(hdt_pkg::NUM_DATA_CH);
    end
    return sum[5:0];
  endfunction

  // reverse bit order inside each byte
  function automatic logic [23:0] rev_bytes(input logic [23:0] v);
    logic [23:0] r;
    for (int b = 0; b < 3; b++) begin
      for (int i = 0; i < 8; i++) begin
        r[b*8 + 7 - i] = v[b*8 + i];
      end
    end
    return r;
  endfunction

  logic [1:0]          mode_q, mode_d;
  logic [5:0]          ch_q, ch_d;
  logic [4:0]          hop_q, hop_d;
  logic [IvlW-1:0]     ivl_q, ivl_d;
  logic [TimeBits-1:0] mark_q, mark_d;
  logic [31:0]         aa_q, aa_d;
  logic [23:0]         crc_q, crc_d;

  logic [63:0]           now_wide;
  logic [TimeBits-1:0]   now_t;
  logic [TimeBits-1:0]   mark_eff;
  logic [TimeBits-1:0]   elapsed;
  logic [63:0]           elapsed_w;
  logic [hdt_pkg::GUARD_BITS-1:0] guard_sel;
  logic [IvlW-1:0]       guard_w;
  logic                  time_up;
  logic [IvlW:0]         ivl_prod;
  logic                  retune, load, refused;

  assign now_wide  = 64'(item_i.now_us);
  assign now_t     = now_wide[TimeBits-1:0];
  assign mark_eff  = (mode_q == hdt_pkg::MODE_WAIT_HOP && item_i.crc_ok) ? now_t : mark_q;
  assign elapsed   = now_t - mark_eff;
  assign elapsed_w = 64'(elapsed);
  assign guard_sel = (mode_q == hdt_pkg::MODE_TIMED_HOP) ? hop_guard_i : skip_guard_i;
  assign guard_w   = IvlW'(guard_sel);
  assign ivl_prod  = (IvlW+1)'(item_i.conn_interval) * (IvlW+1)'(hdt_pkg::US_PER_UNIT);

  always_comb begin
    if (guard_w >= ivl_q) begin
      time_up = (guard_w > ivl_q) || (elapsed != '0);
    end else begin
      time_up = elapsed_w > 64'(ivl_q - guard_w);
    end
  end

  always_comb begin
    mode_d  = mode_q;
    ch_d    = ch_q;
    hop_d   = hop_q;
    ivl_d   = ivl_q;
    mark_d  = mark_q;
    aa_d    = aa_q;
    crc_d   = crc_q;
    retune  = 1'b0;
    load    = 1'b0;
    refused = 1'b0;
    case (mode_q)
      hdt_pkg::MODE_IDLE: begin
        if (item_i.crc_ok && item_i.link_request) begin
          if (item_i.channel_map != hdt_pkg::FULL_MAP) begin
            refused = 1'b1;
          end else begin
            hop_d  = item_i.hop_increment;
            ivl_d  = ivl_prod[IvlW] ? hdt_pkg::INTERVAL_MAX : ivl_prod[IvlW-1:0];
            ch_d   = next_ch(ch_q, item_i.hop_increment);
            retune = 1'b1;
            aa_d   = item_i.link_access_addr;
            crc_d  = rev_bytes(item_i.link_crc_init);
            load   = 1'b1;
            mode_d = hdt_pkg::MODE_WAIT_FIRST;
          end
        end
      end
      hdt_pkg::MODE_WAIT_FIRST: begin
        if (item_i.crc_ok) begin
          mark_d = now_t;
          mode_d = hdt_pkg::MODE_TIMED_HOP;
        end
      end
      hdt_pkg::MODE_TIMED_HOP: begin
        if (time_up) begin
          mark_d = now_t;
          ch_d   = next_ch(ch_q, hop_q);
          retune = 1'b1;
          mode_d = hdt_pkg::MODE_WAIT_HOP;
        end
      end
      default: begin
        // a packet re-marks first; the skip check then runs against that mark
        if (item_i.crc_ok) begin
          mark_d = now_t;
          mode_d = hdt_pkg::MODE_TIMED_HOP;
        end
        if (time_up) begin
          mark_d = now_t;
          ch_d   = next_ch(ch_q, hop_q);
          retune = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= hdt_pkg::MODE_IDLE;
      ch_q   <= '0;
      hop_q  <= '0;
      ivl_q  <= '0;
      mark_q <= '0;
      aa_q   <= '0;
      crc_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      ch_q   <= ch_d;
      hop_q  <= hop_d;
      ivl_q  <= ivl_d;
      mark_q <= mark_d;
      aa_q   <= aa_d;
      crc_q  <= crc_d;
    end
  end

  always_comb begin
    res_o.channel         = ch_d;
    res_o.retune          = retune;
    res_o.load_link       = load;
    res_o.access_addr_out = aa_d;
    res_o.crc_init_out    = crc_d;
    res_o.hop_refused     = refused;
    res_o.track_state     = mode_d;
  end

endmodule
`default_nettype wire

/* hdl/ble_data_channel_hop_tracker.sv */
// Top level of the data channel hop tracker: request registers, guard registers, result register.
//
// Usage:
//   in_*  : one request per controller step (packet flag, link setup fields, timestamp).
//   out_* : exactly one result per request, in order.
//   cfg_* : guard registers, index 0 hop guard, index 1 skip guard; write only while idle.
// Path: a request waits in the request register; its result is then registered for out_valid_o.
// Throughput: one request per cycle unless out_stall_i holds a result; the state step is a
//   single pass of compare, add and one-step mod 37 logic between the request and result registers.
// Stall: while out_stall_i holds a result, one more request is taken into the
//   request register; in_stall_o rises only when both registers are full.
// Reset: rst_ni clears the tracking state, link registers and valid flags and sets the
//   guards to 7000 us and 4000 us; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module ble_data_channel_hop_tracker #(
  parameter int unsigned TimeBits = hdt_pkg::TIME_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire hdt_pkg::hdt_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output hdt_pkg::hdt_out_t                   out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [hdt_pkg::GUARD_BITS-1:0] cfg_data_i
);

  logic             req_valid_q, req_valid_d;
  hdt_pkg::hdt_in_t req_q;
  logic             out_valid_q, out_valid_d;
  hdt_pkg::hdt_out_t out_q;
  hdt_pkg::hdt_out_t res;
  logic [hdt_pkg::GUARD_BITS-1:0] hop_guard_q, skip_guard_q;
  logic             advance, in_fire, step;

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = req_valid_q && !advance;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign step        = req_valid_q && advance;
  assign req_valid_d = in_fire || (req_valid_q && !advance);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_guard_q  <= hdt_pkg::HOP_GUARD_RST;
      skip_guard_q <= hdt_pkg::SKIP_GUARD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hdt_pkg::CFG_HOP_GUARD:  hop_guard_q  <= cfg_data_i;
        hdt_pkg::CFG_SKIP_GUARD: skip_guard_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hdt_core #(
    .TimeBits(TimeBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (req_q),
    .hop_guard_i (hop_guard_q),
    .skip_guard_i(skip_guard_q),
    .res_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* hdl/hdt_checker.sv */
// Port-level assertions for the hop tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hdt_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire hdt_pkg::hdt_out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // back pressure only when a result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("request stalled with free result register");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.load_link |->
      out_data_o.retune && out_data_o.track_state == hdt_pkg::MODE_WAIT_FIRST
      && !out_data_o.hop_refused)
    else $error("link load without setup hop");

  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hop_refused |->
      out_data_o.track_state == hdt_pkg::MODE_IDLE && !out_data_o.retune
      && !out_data_o.load_link)
    else $error("refused setup left idle");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.channel < 6'(hdt_pkg::NUM_DATA_CH))
    else $error("channel out of range");

endmodule

bind ble_data_channel_hop_tracker hdt_checker u_hdt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire
